>>> rtl/anfe_pkg.sv
// Package for the ASCII nibble frame encoder with CRC-16.
// Character codes, sequence positions and the CRC byte update; no dependencies.
package anfe_pkg;

  localparam logic [15:0] CRC_POLY = 16'h8F57;
  localparam logic [7:0]  NIB_BASE = 8'h47;  // 'G'
  localparam logic [7:0]  NIB_TOP  = 8'h56;  // 'V'
  localparam logic [7:0]  CH_START = 8'h23;  // '#'
  localparam logic [7:0]  CH_CR    = 8'h0D;

  // Position of a character within the sequence one item can produce.
  typedef enum logic [2:0] {
    SEQ_START  = 3'd0,
    SEQ_MSG_HI = 3'd1,
    SEQ_MSG_LO = 3'd2,
    SEQ_CRC_3  = 3'd3,
    SEQ_CRC_2  = 3'd4,
    SEQ_CRC_1  = 3'd5,
    SEQ_CRC_0  = 3'd6,
    SEQ_CR     = 3'd7
  } seq_pos_e;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic [7:0]  v;
    logic        top;
    c = crc;
    v = b;
    for (int i = 0; i < 8; i++) begin
      top = v[7] ^ c[15];
      c   = {c[14:0], 1'b0};
      if (top) begin
        c = c ^ CRC_POLY;
      end
      v   = {v[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] nib_char(input logic [3:0] nib);
    return NIB_BASE + {4'b0000, nib};
  endfunction

endpackage

>>> rtl/ascii_nibble_frame_encoder_crc16_unit.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_stall_o   msg_byte_i, first_byte_i, last_byte_i
// out       output     out_valid_o/out_stall_i out_char_o, frame_end_o, run_last_o
//
// Each item yields 2 to 8 characters (2, +1 with first_byte, +5 with
// last_byte), one per cycle while out is not stalled.
// The item register reloads in the cycle its last character moves out.
// The CRC byte update is done at input transfer. Reset clears valid flags
// and the CRC. A stall on out holds the output register and the item.
// Uses anfe_pkg.
module ascii_nibble_frame_encoder_crc16_unit import anfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] msg_byte_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       frame_end_o,
  output logic       run_last_o
);

  logic        item_vld_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [15:0] crcv_q;
  seq_pos_e    pos_q, pos_d, end_pos;
  logic [15:0] crc_q, crc_next;

  logic        out_vld_q;
  logic [7:0]  out_char_q, char_d;
  logic        frame_end_q, run_last_q;

  logic out_free, emit, done, in_xfer;

  assign out_free = !out_vld_q || !out_stall_i;
  assign emit     = item_vld_q && out_free;
  assign end_pos  = last_q ? SEQ_CR : SEQ_MSG_LO;
  assign done     = emit && (pos_q == end_pos);
  assign in_stall_o = item_vld_q && !done;
  assign in_xfer  = in_valid_i && !in_stall_o;

  assign crc_next = crc_byte(first_byte_i ? 16'h0000 : crc_q, msg_byte_i);

  always_comb begin
    unique case (pos_q)
      SEQ_START:  char_d = CH_START;
      SEQ_MSG_HI: char_d = nib_char(byte_q[7:4]);
      SEQ_MSG_LO: char_d = nib_char(byte_q[3:0]);
      SEQ_CRC_3:  char_d = nib_char(crcv_q[15:12]);
      SEQ_CRC_2:  char_d = nib_char(crcv_q[11:8]);
      SEQ_CRC_1:  char_d = nib_char(crcv_q[7:4]);
      SEQ_CRC_0:  char_d = nib_char(crcv_q[3:0]);
      SEQ_CR:     char_d = CH_CR;
      default:    char_d = CH_CR;
    endcase
  end

  always_comb begin
    pos_d = pos_q;
    if (in_xfer) begin
      pos_d = first_byte_i ? SEQ_START : SEQ_MSG_HI;
    end else if (emit) begin
      pos_d = seq_pos_e'(pos_q + 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      pos_q      <= SEQ_START;
      crc_q      <= 16'h0000;
      out_vld_q  <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (in_xfer) begin
        item_vld_q <= 1'b1;
        crc_q      <= last_byte_i ? 16'h0000 : crc_next;
      end else if (done) begin
        item_vld_q <= 1'b0;
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= msg_byte_i;
      last_q <= last_byte_i;
      crcv_q <= crc_next;
    end
    if (emit) begin
      out_char_q  <= char_d;
      frame_end_q <= (pos_q == SEQ_CR);
      run_last_q  <= (pos_q == end_pos);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_char_o  = out_char_q;
  assign frame_end_o = frame_end_q;
  assign run_last_o  = run_last_q;

endmodule

>>> rtl/anfe_checker.sv
// Port-level checks for the ASCII nibble frame encoder, bound to the top level.
// Uses anfe_pkg for character codes.
module anfe_checker import anfe_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_char_o,
  input logic       frame_end_o,
  input logic       run_last_o
);

  a_end_is_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> (out_char_o == CH_CR) && run_last_o)
    else $error("frame end without closing CR");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_char_o == CH_START) || (out_char_o == CH_CR) ||
                    ((out_char_o >= NIB_BASE) && (out_char_o <= NIB_TOP)))
    else $error("character outside code set");

  a_start_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_char_o == CH_START)) |-> !run_last_o && !frame_end_o)
    else $error("start mark closes an item");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(out_char_o) &&
                                     $stable(run_last_o))
    else $error("stalled transfer changed");

endmodule

bind ascii_nibble_frame_encoder_crc16_unit anfe_checker u_anfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_char_o  (out_char_o),
  .frame_end_o (frame_end_o),
  .run_last_o  (run_last_o)
);
